// ----- sv/spq_pkg.sv -----
// spq_pkg: widths, command and error codes and the control bundle of the
// sorted priority queue. No dependencies; used by spq_cell and the top level.
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int KEY_W  = 32;
	localparam int TAG_W  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// commands
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// error codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	// register indexes
	localparam logic REG_SIGNED_KEYS = 1'b0;

	// broadcast to every cell of the row
	typedef struct packed {
		logic             insert;
		logic             remove;
		logic             signed_keys;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} spq_ctl_t;

endpackage

// ----- sv/spq_cell.sv -----
// spq_cell: one slot of the sorted row; holds a key/tag entry and swaps it
// with its neighbors on insert and remove. Depends on spq_pkg.
module spq_cell
	import spq_pkg::*;
(
	input  logic             clk,
	input  logic             is_head,
	input  logic             valid,
	input  spq_ctl_t         ctl,
	input  logic             left_ins,
	input  logic [KEY_W-1:0] left_key,
	input  logic [TAG_W-1:0] left_tag,
	input  logic [KEY_W-1:0] right_key,
	input  logic [TAG_W-1:0] right_tag,
	output logic             ins,
	output logic [KEY_W-1:0] key_q,
	output logic [TAG_W-1:0] tag_q
);

	logic [KEY_W-1:0] sign_flip;
	logic [KEY_W-1:0] rank_own;
	logic [KEY_W-1:0] rank_new;
	logic             new_gt;
	logic             new_ge;

	// map keys to an unsigned rank in the configured order
	assign sign_flip = {ctl.signed_keys, {(KEY_W-1){1'b0}}};
	assign rank_own  = key_q ^ sign_flip;
	assign rank_new  = ctl.key ^ sign_flip;
	assign new_gt    = rank_new > rank_own;
	assign new_ge    = rank_new >= rank_own;

	// new entry lands at or before this slot
	assign ins = !valid || (is_head ? new_gt : new_ge);

	// shift right on insert, shift left on remove
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_ins) begin
				key_q <= left_key;
				tag_q <= left_tag;
			end else if (ins) begin
				key_q <= ctl.key;
				tag_q <= ctl.tag;
			end
		end else if (ctl.remove) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end
	end

endmodule

// ----- sv/sorted_priority_queue_top.sv -----
// sorted_priority_queue_top: sorted priority queue built as a row of
// spq_cell slots with count, result register and APB register port.
// Depends on spq_pkg and spq_cell.
//
// Usage: the input channel (in_valid/in_ready) carries a command with key
// and tag; command insert places the entry in descending key order,
// command remove drops the head. Each accepted beat yields exactly one
// result beat on the output channel (out_valid/out_ready): head key and
// tag after the command, count, empty flag and error code.
// The result is registered and appears in the cycle after acceptance.
// Throughput is one command per cycle while the receiver takes each
// result; every slot compares the new key against its own entry in
// parallel and shifts by one position, whatever the fill level.
// When the receiver stalls, the result stays registered and in_ready drops
// until it is taken; a new command is accepted in the same cycle the
// pending result leaves. Reset empties the queue (count zero), clears any
// pending result and sets key order to unsigned. Register signed_keys at
// byte address 0 selects two's complement key order; write it only idle.
module sorted_priority_queue_top
	import spq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// command channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [KEY_W-1:0]  key,
	input  logic [TAG_W-1:0]  tag,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KEY_W-1:0]  max_key,
	output logic [TAG_W-1:0]  max_tag,
	output logic [CNT_W-1:0]  count,
	output logic              empty_res,
	output logic [1:0]        error
);

	logic             signed_keys_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       error_q;
	logic             out_valid_q;
	logic             accept;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             do_rem;
	spq_ctl_t         ctl;

	logic [KEY_W-1:0] cell_key [DEPTH];
	logic [TAG_W-1:0] cell_tag [DEPTH];
	logic             cell_ins [DEPTH];

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIGNED_KEYS) ?
		{{(DATA_W-1){1'b0}}, signed_keys_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_keys_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == REG_SIGNED_KEYS)) begin
			signed_keys_q <= pwdata[0];
		end
	end

	// command decode
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign do_ins   = accept && (command == CMD_INSERT) && !full;
	assign do_rem   = accept && (command == CMD_REMOVE) && !empty;

	assign ctl.insert      = do_ins;
	assign ctl.remove      = do_rem;
	assign ctl.signed_keys = signed_keys_q;
	assign ctl.key         = key;
	assign ctl.tag         = tag;

	// row of slots
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             left_ins;
		logic [KEY_W-1:0] left_key;
		logic [TAG_W-1:0] left_tag;
		logic [KEY_W-1:0] right_key;
		logic [TAG_W-1:0] right_tag;

		if (i == 0) begin : g_first
			assign left_ins = 1'b0;
			assign left_key = '0;
			assign left_tag = '0;
		end else begin : g_mid
			assign left_ins = cell_ins[i-1];
			assign left_key = cell_key[i-1];
			assign left_tag = cell_tag[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_key = '0;
			assign right_tag = '0;
		end else begin : g_inner
			assign right_key = cell_key[i+1];
			assign right_tag = cell_tag[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.is_head   (i == 0),
			.valid     (count_q > CNT_W'(i)),
			.ctl       (ctl),
			.left_ins  (left_ins),
			.left_key  (left_key),
			.left_tag  (left_tag),
			.right_key (right_key),
			.right_tag (right_tag),
			.ins       (cell_ins[i]),
			.key_q     (cell_key[i]),
			.tag_q     (cell_tag[i])
		);
	end

	// fill count, error code and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			error_q     <= ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_rem) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
				priority if (command == CMD_INSERT && full) begin
					error_q <= ERR_FULL;
				end else if (command == CMD_REMOVE && empty) begin
					error_q <= ERR_EMPTY;
				end else begin
					error_q <= ERR_OK;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the row only moves when the pending result is taken, so it is read live
	assign out_valid = out_valid_q;
	assign max_key   = empty ? '0 : cell_key[0];
	assign max_tag   = empty ? '0 : cell_tag[0];
	assign count     = count_q;
	assign empty_res = empty;
	assign error     = error_q;

endmodule
